// ----- hdl/desp_pkg.sv -----
// Package for the dual encoder speed and position block.
// Holds register indexes, reset values, scaling constants and the controller command struct.
// Used by desp_ctrl, desp_datapath and dual_encoder_speed_position.
package desp_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int ADDR_WIDTH = 4;
    localparam int DATA_WIDTH = 32;

    localparam logic [1:0] REG_PULSES_PER_REV     = 2'd0;
    localparam logic [1:0] REG_SAMPLES_PER_SECOND = 2'd1;
    localparam logic [1:0] REG_INVERT_ONE         = 2'd2;
    localparam logic [1:0] REG_INVERT_TWO         = 2'd3;

    localparam logic [15:0] PPR_RESET    = 16'd600;
    localparam logic [9:0]  SPS_RESET    = 10'd10;
    localparam logic        INV_ONE_RESET = 1'b0;
    localparam logic        INV_TWO_RESET = 1'b1;

    localparam logic [15:0] SECONDS_PER_MINUTE = 16'd60;
    localparam logic [15:0] DEGREES_PER_REV    = 16'd360;

    localparam int QUO_BITS  = 15;
    localparam int PROD_BITS = 48;

    localparam logic [1:0] JOB_RPM_ONE      = 2'd0;
    localparam logic [1:0] JOB_RPM_TWO      = 2'd1;
    localparam logic [1:0] JOB_POSITION_ONE = 2'd2;
    localparam logic [1:0] JOB_POSITION_TWO = 2'd3;

    localparam logic [15:0] SAT_POS = 16'h7FFF;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic       mul;
        logic       chk;
        logic       div_step;
        logic       write;
        logic       clear_period;
        logic       out_load;
        logic [1:0] job;
    } t_dp_cmd;

endpackage

// ----- hdl/desp_ctrl.sv -----
// Controller state machine for the dual encoder speed and position block.
// Sequences the shared multiply and divide unit and drives the request handshakes.
// Depends on desp_pkg.
module desp_ctrl
    import desp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_cmd,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_dp_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [3:0] LAST_STEP = 4'(QUO_BITS - 1);

    logic [2:0] r_state, n_state;
    logic [1:0] r_job, n_job;
    logic [3:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       out_load;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_job   = i_cmd ? JOB_RPM_ONE : JOB_POSITION_ONE;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_step  = 4'd0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_WRITE;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_WRITE: begin
                if (r_job == JOB_POSITION_TWO) begin
                    n_state = S_DONE;
                end else begin
                    n_job   = r_job + 2'd1;
                    n_state = S_LOAD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= JOB_RPM_ONE;
            r_step      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_dp_cmd              = '0;
        o_dp_cmd.accept       = accept;
        o_dp_cmd.load         = (r_state == S_LOAD);
        o_dp_cmd.mul          = (r_state == S_MUL);
        o_dp_cmd.chk          = (r_state == S_CHK);
        o_dp_cmd.div_step     = (r_state == S_DIV);
        o_dp_cmd.write        = (r_state == S_WRITE);
        o_dp_cmd.clear_period = (r_state == S_WRITE) && (r_job == JOB_RPM_TWO);
        o_dp_cmd.out_load     = out_load;
        o_dp_cmd.job          = r_job;
    end

endmodule

// ----- hdl/desp_datapath.sv -----
// Datapath for the dual encoder speed and position block.
// Holds the counters, latched speeds, shared multiply and serial divide, and output registers.
// Depends on desp_pkg and the commands of desp_ctrl.
module desp_datapath
    import desp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_dp_cmd,
    input  logic        i_cmd,
    input  logic [1:0]  i_edge_pin,
    input  logic        i_other_level,
    input  logic [15:0] i_pulses_per_rev,
    input  logic [9:0]  i_samples_per_second,
    input  logic        i_invert_one,
    input  logic        i_invert_two,
    output logic [15:0] o_speed_one,
    output logic [15:0] o_speed_two,
    output logic [15:0] o_position_one,
    output logic [15:0] o_position_two,
    output logic [31:0] o_count_one,
    output logic [31:0] o_count_two
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic [COUNT_WIDTH-1:0] r_period_one, r_period_two;
    logic [COUNT_WIDTH-1:0] r_total_one, r_total_two;
    logic [15:0]            r_rpm_one, r_rpm_two;
    logic [15:0]            r_ang_one, r_ang_two;

    logic                   r_neg;
    logic                   r_big;
    logic [31:0]            r_mag;
    logic [15:0]            r_factor;
    logic [PROD_BITS-1:0]   r_prod;
    logic                   r_zero;
    logic                   r_sat;
    logic [15:0]            r_rem;
    logic [QUO_BITS-1:0]    r_low;
    logic [QUO_BITS-1:0]    r_quo;

    logic [15:0] r_out_speed_one, r_out_speed_two;
    logic [15:0] r_out_position_one, r_out_position_two;
    logic [31:0] r_out_count_one, r_out_count_two;

    logic                   step_en;
    logic                   step_one;
    logic                   step_up;
    logic [COUNT_WIDTH-1:0] step_delta;
    logic [COUNT_WIDTH-1:0] sel_val;
    logic                   sel_neg;
    logic [COUNT_WIDTH-1:0] sel_mag;
    logic [31:0]            mag_low;
    logic                   mag_big;
    logic [15:0]            factor;
    logic [16:0]            div_trial;
    logic [16:0]            div_diff;
    logic                   div_bit;
    logic [15:0]            result;
    logic [15:0]            quo_ext;
    logic [31:0]            count_one_sat, count_two_sat;

    assign step_en    = i_dp_cmd.accept && !i_cmd && !i_other_level;
    assign step_one   = !i_edge_pin[1];
    assign step_up    = !i_edge_pin[0] ^ (step_one ? i_invert_one : i_invert_two);
    assign step_delta = step_up ? CNT_ONE : ~CNT_ONE + CNT_ONE;

    always_comb begin
        case (i_dp_cmd.job)
            JOB_RPM_ONE:      sel_val = r_period_one;
            JOB_RPM_TWO:      sel_val = r_period_two;
            JOB_POSITION_ONE: sel_val = r_total_one;
            default:          sel_val = r_total_two;
        endcase
    end

    assign sel_neg = sel_val[COUNT_WIDTH-1];
    assign sel_mag = sel_neg ? (~sel_val + CNT_ONE) : sel_val;
    assign factor  = (i_dp_cmd.job == JOB_RPM_ONE || i_dp_cmd.job == JOB_RPM_TWO)
                   ? 16'(16'(i_samples_per_second) * SECONDS_PER_MINUTE)
                   : DEGREES_PER_REV;

    generate
        if (COUNT_WIDTH < 32) begin : g_narrow
            assign mag_low = {{(32 - COUNT_WIDTH){1'b0}}, sel_mag};
            assign mag_big = 1'b0;
            assign count_one_sat = {{(32 - COUNT_WIDTH){r_period_one[COUNT_WIDTH-1]}},
                                    r_period_one};
            assign count_two_sat = {{(32 - COUNT_WIDTH){r_period_two[COUNT_WIDTH-1]}},
                                    r_period_two};
        end else if (COUNT_WIDTH == 32) begin : g_exact
            assign mag_low       = sel_mag;
            assign mag_big       = 1'b0;
            assign count_one_sat = r_period_one;
            assign count_two_sat = r_period_two;
        end else begin : g_wide
            logic [COUNT_WIDTH-32:0] hi_one, hi_two;
            assign mag_low = sel_mag[31:0];
            assign mag_big = |sel_mag[COUNT_WIDTH-1:32];
            assign hi_one  = r_period_one[COUNT_WIDTH-1:31];
            assign hi_two  = r_period_two[COUNT_WIDTH-1:31];
            assign count_one_sat = ((&hi_one) || !(|hi_one)) ? r_period_one[31:0]
                                 : (r_period_one[COUNT_WIDTH-1] ? 32'h8000_0000
                                                                : 32'h7FFF_FFFF);
            assign count_two_sat = ((&hi_two) || !(|hi_two)) ? r_period_two[31:0]
                                 : (r_period_two[COUNT_WIDTH-1] ? 32'h8000_0000
                                                                : 32'h7FFF_FFFF);
        end
    endgenerate

    assign div_trial = {r_rem, r_low[QUO_BITS-1]};
    assign div_diff  = div_trial - {1'b0, i_pulses_per_rev};
    assign div_bit   = (div_trial >= {1'b0, i_pulses_per_rev});
    assign quo_ext   = {1'b0, r_quo};

    always_comb begin
        if (r_zero) begin
            result = 16'd0;
        end else if (r_sat) begin
            result = r_neg ? SAT_NEG : SAT_POS;
        end else if (r_neg) begin
            result = ~quo_ext + 16'd1;
        end else begin
            result = quo_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_one <= '0;
            r_period_two <= '0;
            r_total_one  <= '0;
            r_total_two  <= '0;
            r_rpm_one    <= '0;
            r_rpm_two    <= '0;
        end else begin
            if (step_en && step_one) begin
                r_period_one <= r_period_one + step_delta;
                r_total_one  <= r_total_one + step_delta;
            end
            if (step_en && !step_one) begin
                r_period_two <= r_period_two + step_delta;
                r_total_two  <= r_total_two + step_delta;
            end
            if (i_dp_cmd.clear_period) begin
                r_period_one <= '0;
                r_period_two <= '0;
            end
            if (i_dp_cmd.write && i_dp_cmd.job == JOB_RPM_ONE) begin
                r_rpm_one <= result;
            end
            if (i_dp_cmd.write && i_dp_cmd.job == JOB_RPM_TWO) begin
                r_rpm_two <= result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_neg    <= sel_neg;
            r_mag    <= mag_low;
            r_big    <= mag_big;
            r_factor <= factor;
        end
        if (i_dp_cmd.mul) begin
            r_prod <= PROD_BITS'(r_mag) * PROD_BITS'(r_factor);
        end
        if (i_dp_cmd.chk) begin
            r_zero <= (r_factor == '0) || (!r_big && (r_mag == '0));
            r_sat  <= r_big || (r_prod >= {17'd0, i_pulses_per_rev, 15'd0});
            r_rem  <= r_prod[30:15];
            r_low  <= r_prod[QUO_BITS-1:0];
            r_quo  <= '0;
        end
        if (i_dp_cmd.div_step) begin
            r_rem <= div_bit ? div_diff[15:0] : div_trial[15:0];
            r_low <= {r_low[QUO_BITS-2:0], 1'b0};
            r_quo <= {r_quo[QUO_BITS-2:0], div_bit};
        end
        if (i_dp_cmd.write && i_dp_cmd.job == JOB_POSITION_ONE) begin
            r_ang_one <= result;
        end
        if (i_dp_cmd.write && i_dp_cmd.job == JOB_POSITION_TWO) begin
            r_ang_two <= result;
        end
        if (i_dp_cmd.out_load) begin
            r_out_speed_one    <= r_rpm_one;
            r_out_speed_two    <= r_rpm_two;
            r_out_position_one <= r_ang_one;
            r_out_position_two <= r_ang_two;
            r_out_count_one    <= count_one_sat;
            r_out_count_two    <= count_two_sat;
        end
    end

    assign o_speed_one    = r_out_speed_one;
    assign o_speed_two    = r_out_speed_two;
    assign o_position_one = r_out_position_one;
    assign o_position_two = r_out_position_two;
    assign o_count_one    = r_out_count_one;
    assign o_count_two    = r_out_count_two;

endmodule

// ----- hdl/dual_encoder_speed_position.sv -----
// Top level of the dual quadrature encoder speed and position block.
// Holds the configuration registers and joins desp_ctrl with desp_datapath.
// Depends on desp_pkg, desp_ctrl and desp_datapath.
//
// Usage: each input request is either a pin edge event (i_cmd low) or a sample
// tick (i_cmd high). It is taken when i_in_valid is high and o_in_stall is low.
// Every request yields exactly one result request on o_out_valid, carrying both
// latched speeds, both angles and both period counts after the update.
// An edge event needs two scalings and a sample tick four, run one after the
// other on the shared multiplier and the one-bit-per-cycle divider; each
// scaling steps through load, multiply, range check, 15 divide steps and
// write. The next request can be taken in the cycle after the result is
// loaded into the output register. One request is worked on at a time; the
// next is taken while a finished result still waits in the output register.
// If the receiver stalls, the result holds and a second finished result waits
// inside until the register is free.
// Reset clears counts, totals and speeds and restores the register defaults.
// Configuration is to be written over the APB port while the block is idle; the
// block itself does not enforce this.
module dual_encoder_speed_position
    import desp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [1:0]            i_edge_pin,
    input  logic                  i_other_level,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_speed_one,
    output logic signed [15:0]    o_speed_two,
    output logic signed [15:0]    o_position_one,
    output logic signed [15:0]    o_position_two,
    output logic signed [31:0]    o_count_one,
    output logic signed [31:0]    o_count_two,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    logic [15:0] r_pulses_per_rev;
    logic [9:0]  r_samples_per_second;
    logic        r_invert_one;
    logic        r_invert_two;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    t_dp_cmd     dp_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulses_per_rev     <= PPR_RESET;
            r_samples_per_second <= SPS_RESET;
            r_invert_one         <= INV_ONE_RESET;
            r_invert_two         <= INV_TWO_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_PULSES_PER_REV:     r_pulses_per_rev     <= pwdata[15:0];
                REG_SAMPLES_PER_SECOND: r_samples_per_second <= pwdata[9:0];
                REG_INVERT_ONE:         r_invert_one         <= pwdata[0];
                REG_INVERT_TWO:         r_invert_two         <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_PULSES_PER_REV:     prdata = {16'd0, r_pulses_per_rev};
            REG_SAMPLES_PER_SECOND: prdata = {22'd0, r_samples_per_second};
            REG_INVERT_ONE:         prdata = {31'd0, r_invert_one};
            REG_INVERT_TWO:         prdata = {31'd0, r_invert_two};
            default:                prdata = '0;
        endcase
    end

    desp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_dp_cmd    (dp_cmd)
    );

    desp_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_dp_cmd             (dp_cmd),
        .i_cmd                (i_cmd),
        .i_edge_pin           (i_edge_pin),
        .i_other_level        (i_other_level),
        .i_pulses_per_rev     (r_pulses_per_rev),
        .i_samples_per_second (r_samples_per_second),
        .i_invert_one         (r_invert_one),
        .i_invert_two         (r_invert_two),
        .o_speed_one          (o_speed_one),
        .o_speed_two          (o_speed_two),
        .o_position_one       (o_position_one),
        .o_position_two       (o_position_two),
        .o_count_one          (o_count_one),
        .o_count_two          (o_count_two)
    );

    a_no_result_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid)
    ) else $error("A result appeared one cycle after a request was taken.");

    a_ready_on_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall
    ) else $error("The block was not ready for a request when a result was issued.");

    a_stall_until_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("A second request was taken before the first one finished.");

endmodule

// ----- tb/sv/tb_dual_encoder_speed_position.sv -----
// Self-checking testbench for dual_encoder_speed_position, using desp_pkg for port widths.
// Directed and random encoder edge and sample tick requests are checked against a built-in
// predictor of counts, speeds and angles, with random idling on both channels.
module tb_dual_encoder_speed_position;
    import desp_pkg::*;

    localparam logic       CMD_EDGE = 1'b0;
    localparam logic       CMD_TICK = 1'b1;
    localparam logic [1:0] PIN_A1   = 2'd0;
    localparam logic [1:0] PIN_B1   = 2'd1;
    localparam logic [1:0] PIN_A2   = 2'd2;
    localparam logic [1:0] PIN_B2   = 2'd3;

    localparam int SEC_PER_MIN = 60;
    localparam int DEG_PER_REV = 360;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic signed [15:0] speed_one;
        logic signed [15:0] speed_two;
        logic signed [15:0] position_one;
        logic signed [15:0] position_two;
        logic signed [31:0] count_one;
        logic signed [31:0] count_two;
    } t_reading;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_cmd;
    logic [1:0]            i_edge_pin;
    logic                  i_other_level;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [15:0]    o_speed_one;
    logic signed [15:0]    o_speed_two;
    logic signed [15:0]    o_position_one;
    logic signed [15:0]    o_position_two;
    logic signed [31:0]    o_count_one;
    logic signed [31:0]    o_count_two;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    logic [15:0] cfg_ppr;
    logic [9:0]  cfg_sps;
    logic        cfg_invert [2];
    logic [31:0] period_pulses [2];
    logic [31:0] total_pulses [2];
    logic [15:0] latched_rpm [2];

    t_reading pending_readings [$];
    int       mismatch_count = 0;
    int       quiet_cycles = 0;
    int       send_idle_pct = 25;
    int       recv_stall_pct = 80;

    dual_encoder_speed_position DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_edge_pin     (i_edge_pin),
        .i_other_level  (i_other_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_speed_one    (o_speed_one),
        .o_speed_two    (o_speed_two),
        .o_position_one (o_position_one),
        .o_position_two (o_position_two),
        .o_count_one    (o_count_one),
        .o_count_two    (o_count_two),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Truncates value * factor / pulses_per_rev toward zero and saturates to 16 bits.
    function automatic logic [15:0] scaled_saturated(logic [31:0] value, logic [31:0] factor);
        logic [31:0] mag;
        logic [63:0] quotient;
        mag = value[31] ? 32'(-value) : value;
        if (mag == 32'd0 || factor == 32'd0) return 16'h0000;
        if (cfg_ppr == 16'd0) quotient = 64'd1 << 20;
        else quotient = (64'(mag) * 64'(factor)) / 64'(cfg_ppr);
        if (value[31]) return (quotient >= 64'd32768) ? 16'h8000 : 16'(64'd0 - quotient);
        return (quotient > 64'd32767) ? 16'h7FFF : quotient[15:0];
    endfunction

    function automatic t_reading predict_reading(logic cmd, logic [1:0] pin, logic other);
        t_reading r;
        logic [31:0] factor;
        int enc;
        logic up;
        if (cmd == CMD_TICK) begin
            factor = 32'(cfg_sps) * SEC_PER_MIN;
            for (int e = 0; e < 2; e++) begin
                latched_rpm[e] = scaled_saturated(period_pulses[e], factor);
                period_pulses[e] = 32'd0;
            end
        end else if (!other) begin
            enc = pin[1];
            up = !pin[0] ^ cfg_invert[enc];
            period_pulses[enc] = period_pulses[enc] + (up ? 32'd1 : 32'hFFFF_FFFF);
            total_pulses[enc] = total_pulses[enc] + (up ? 32'd1 : 32'hFFFF_FFFF);
        end
        r.speed_one = latched_rpm[0];
        r.speed_two = latched_rpm[1];
        r.position_one = scaled_saturated(total_pulses[0], DEG_PER_REV);
        r.position_two = scaled_saturated(total_pulses[1], DEG_PER_REV);
        r.count_one = period_pulses[0];
        r.count_two = period_pulses[1];
        return r;
    endfunction

    function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_reading want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_readings.size() == 0) begin
                $error("result arrived with no request pending");
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("speed_one", want.speed_one, o_speed_one);
                check_field("speed_two", want.speed_two, o_speed_two);
                check_field("position_one", want.position_one, o_position_one);
                check_field("position_two", want.position_two, o_position_two);
                check_field("count_one", want.count_one, o_count_one);
                check_field("count_two", want.count_two, o_count_two);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic cmd, input logic [1:0] pin, input logic other);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd = cmd;
        i_edge_pin = pin;
        i_other_level = other;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_readings.push_back(predict_reading(cmd, pin, other));
    endtask

    task automatic wait_until_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_WIDTH'({index, 2'b00});
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (index)
            REG_PULSES_PER_REV:     cfg_ppr = value[15:0];
            REG_SAMPLES_PER_SECOND: cfg_sps = value[9:0];
            REG_INVERT_ONE:         cfg_invert[0] = value[0];
            REG_INVERT_TWO:         cfg_invert[1] = value[0];
            default: ;
        endcase
    endtask

    task automatic configure_block(input logic [15:0] ppr, input logic [9:0] sps,
                                   input logic inv_one, input logic inv_two);
        wait_until_idle();
        write_register(REG_PULSES_PER_REV, 32'(ppr));
        write_register(REG_SAMPLES_PER_SECOND, 32'(sps));
        write_register(REG_INVERT_ONE, 32'(inv_one));
        write_register(REG_INVERT_TWO, 32'(inv_two));
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic test_pin_decoding();
        for (int p = 0; p < 4; p++) begin
            for (int lvl = 0; lvl < 2; lvl++) begin
                send_request(CMD_EDGE, 2'(p), 1'(lvl));
            end
        end
        send_request(CMD_EDGE, PIN_A1, 1'b0);
        send_request(CMD_EDGE, PIN_A1, 1'b0);
        send_request(CMD_EDGE, PIN_A2, 1'b0);
        send_request(CMD_TICK, PIN_B2, 1'b1);
    endtask

    task automatic test_speed_saturation();
        configure_block(16'd1, 10'd1023, 1'b1, 1'b0);
        send_request(CMD_EDGE, PIN_A1, 1'b0);
        send_request(CMD_EDGE, PIN_A2, 1'b0);
        send_request(CMD_TICK, PIN_A1, 1'b0);
        send_request(CMD_EDGE, PIN_B1, 1'b0);
        send_request(CMD_TICK, PIN_A2, 1'b1);
    endtask

    task automatic test_zero_divisors();
        configure_block(16'd0, 10'd0, 1'b0, 1'b1);
        send_request(CMD_EDGE, PIN_A1, 1'b0);
        send_request(CMD_TICK, PIN_B1, 1'b0);
        configure_block(16'd0, 10'd7, 1'b0, 1'b0);
        send_request(CMD_EDGE, PIN_B2, 1'b0);
        send_request(CMD_EDGE, PIN_A1, 1'b0);
        send_request(CMD_TICK, PIN_B1, 1'b1);
        send_request(CMD_TICK, PIN_A2, 1'b0);
    endtask

    // Runs of same-direction steps on one encoder, mixed with ticks and random edges.
    task automatic test_random_motion(input int n_items, input int lean_pct);
        int enc;
        int run_left;
        int roll;
        logic run_up;
        logic fwd;
        enc = 0;
        run_left = 0;
        run_up = 1'b0;
        repeat (n_items) begin
            if (run_left == 0) begin
                enc = $urandom_range(1);
                run_up = ($urandom_range(99) < lean_pct);
                run_left = $urandom_range(32, 1);
            end
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_request(CMD_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
            end else if (roll < 20) begin
                send_request(CMD_EDGE, 2'($urandom_range(3)), 1'($urandom_range(1)));
            end else begin
                fwd = run_up ^ cfg_invert[enc];
                send_request(CMD_EDGE, {1'(enc), ~fwd}, 1'b0);
                run_left--;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_EDGE;
        i_edge_pin = PIN_A1;
        i_other_level = 1'b0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_ppr = 16'd600;
        cfg_sps = 10'd10;
        cfg_invert[0] = 1'b0;
        cfg_invert[1] = 1'b1;
        for (int e = 0; e < 2; e++) begin
            period_pulses[e] = 32'd0;
            total_pulses[e] = 32'd0;
            latched_rpm[e] = 16'd0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 25;
        recv_stall_pct = 80;
        test_pin_decoding();
        test_speed_saturation();
        test_zero_divisors();
        configure_block(16'd600, 10'd10, 1'b0, 1'b1);
        test_random_motion(100, 85);
        configure_block(16'd1, 10'd1023, 1'b0, 1'b1);
        test_random_motion(100, 85);

        send_idle_pct = 80;
        recv_stall_pct = 25;
        configure_block(16'd65535, 10'd1000, 1'b1, 1'b0);
        test_random_motion(100, 50);
        configure_block(16'd0, 10'd1, 1'b1, 1'b1);
        test_random_motion(100, 15);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure_block(16'd1, 10'd1, 1'b0, 1'b0);
        test_random_motion(120, 15);
        configure_block(16'($urandom_range(65535, 1)), 10'($urandom_range(1023)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
        test_random_motion(60, 50);

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/desp_pkg.sv
hdl/desp_ctrl.sv
hdl/desp_datapath.sv
hdl/dual_encoder_speed_position.sv
tb/sv/tb_dual_encoder_speed_position.sv
